/* rtl/core/lcr_pkg.sv */
package lcr_pkg;

  // converter word and derived widths
  localparam int ADC_BITS = 24;
  localparam int RAW_W    = 24;
  localparam int WIDE_W   = (ADC_BITS > RAW_W) ? ADC_BITS : RAW_W;
  localparam int DIFF_W   = WIDE_W + 1;
  localparam int NUM_W    = DIFF_W + 8;
  localparam int SAT_W    = NUM_W + 1;
  localparam int WEIGHT_W = 33;
  localparam int SUM_W    = ADC_BITS + 8;
  localparam int PCNT_W   = $clog2(ADC_BITS + 1);

  // shared divider
  localparam int DIV_W     = NUM_W;
  localparam int DVSR_W    = 24;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CAL_W      = 24;
  localparam int TSAMP_W    = 8;
  localparam int GAIN_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PULSES  = 2'd2;

  localparam logic [CAL_W-1:0]   CAL_RESET   = 24'd1;
  localparam logic [TSAMP_W-1:0] TSAMP_RESET = 8'd10;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 2'd1;

  // weight saturation limits
  localparam logic [33:0] Q33_POS_MAG = 34'h0_FFFF_FFFF;
  localparam logic [33:0] Q33_NEG_MAG = 34'h1_0000_0000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 33'h0_FFFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 33'h1_0000_0000;

  // front to back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SHIFT,
    PH_GAIN
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WSTART,
    BK_WDIV,
    BK_TSTART,
    BK_TDIV
  } bk_state_t;

  // one classified tick
  typedef struct packed {
    logic                sck;
    logic                sample;
    logic                req;
    logic [ADC_BITS-1:0] word;
  } lcr_rec_t;

  // low raw bits of a converter word, sign-extended
  function automatic logic signed [RAW_W-1:0] to_raw24(input logic [ADC_BITS-1:0] w);
    logic signed [WIDE_W-1:0] x;
    x = WIDE_W'(signed'(w));
    return x[RAW_W-1:0];
  endfunction

endpackage

/* rtl/core/load_cell_adc_reader_with_tare.sv */
// channel   dir  handshake            payload
// cfg       in   cfg_valid/cfg_ready  cfg_index (2b), cfg_data (24b)
// in        in   in_valid/in_ready    req_type, dout_level
// out       out  out_valid/out_ready  sck_level, sample_valid, raw_count, weight_q8,
//                                     tare_busy, tare_done, tare_level
//
// one result item per tick; ticks that complete no reading stream at one per clock
// while out_ready stays high; a tick that completes a reading holds the back end while the
// shared divider retires one quotient bit per clock over the 33-bit weight numerator
// a reading that also closes a tare then runs a second divide for the tare average
// a 4-entry queue lets the front keep taking ticks while the back end divides
// sync reset clears control, tare state and config; no memory clearing pass
module load_cell_adc_reader_with_tare (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes, always accepted
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]      cfg_data,
  // tick items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic                                dout_level,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                sck_level,
  output logic                                sample_valid,
  output logic signed [lcr_pkg::RAW_W-1:0]    raw_count,
  output logic signed [lcr_pkg::WEIGHT_W-1:0] weight_q8,
  output logic                                tare_busy,
  output logic                                tare_done,
  output logic signed [lcr_pkg::RAW_W-1:0]    tare_level
);
  import lcr_pkg::*;

  // config registers
  logic [CAL_W-1:0]   counts_per_unit;
  logic [TSAMP_W-1:0] tare_samples;
  logic [GAIN_W-1:0]  gain_pulses;

  // queue between front and back
  logic     push_valid, push_ready;
  lcr_rec_t push_data;
  logic     pop_valid, pop_ready;
  lcr_rec_t pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_unit <= CAL_RESET;
      tare_samples    <= TSAMP_RESET;
      gain_pulses     <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAL_FACTOR:   counts_per_unit <= cfg_data[CAL_W-1:0];
        CFG_TARE_SAMPLES: tare_samples    <= cfg_data[TSAMP_W-1:0];
        CFG_GAIN_PULSES:  gain_pulses     <= cfg_data[GAIN_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // front: serial clock sequencer, classifies each tick
  lcr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .dout_level  (dout_level),
    .gain_pulses (gain_pulses),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  lcr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: weight divide, tare averaging, result register
  lcr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .counts_per_unit (counts_per_unit),
    .tare_samples    (tare_samples),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sck_level       (sck_level),
    .sample_valid    (sample_valid),
    .raw_count       (raw_count),
    .weight_q8       (weight_q8),
    .tare_busy       (tare_busy),
    .tare_done       (tare_done),
    .tare_level      (tare_level)
  );

endmodule

/* rtl/core/lcr_div.sv */
module lcr_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lcr_pkg::DIV_W-1:0]    dividend,
  input  logic [lcr_pkg::DVSR_W-1:0]   divisor,
  output logic                         done,
  output logic [lcr_pkg::DIV_W-1:0]    quotient
);
  import lcr_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DVSR_W-1:0]    rem;
  logic [DVSR_W-1:0]    dvsr;
  logic [DIV_W-1:0]     work;
  logic [DVSR_W:0]      rem_shift;
  logic [DVSR_W:0]      diff;
  logic                 fits;

  // one restoring step per cycle
  always_comb begin
    rem_shift = {rem, work[DIV_W-1]};
    diff      = rem_shift - {1'b0, dvsr};
    fits      = !diff[DVSR_W];
  end

  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      rem  <= fits ? diff[DVSR_W-1:0] : rem_shift[DVSR_W-1:0];
      work <= {work[DIV_W-2:0], fits};
    end
  end

endmodule

/* rtl/core/lcr_fifo.sv */
module lcr_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  lcr_pkg::lcr_rec_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output lcr_pkg::lcr_rec_t pop_data
);
  import lcr_pkg::*;

  lcr_rec_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

/* rtl/core/lcr_front.sv */
module lcr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic                         dout_level,
  input  logic [lcr_pkg::GAIN_W-1:0]   gain_pulses,
  output logic                         push_valid,
  input  logic                         push_ready,
  output lcr_pkg::lcr_rec_t            push_data
);
  import lcr_pkg::*;

  phase_t              phase, phase_next;
  logic                clock_high, clock_high_next;
  logic [PCNT_W-1:0]   pulse_count, pulse_count_next, pulse_inc;
  logic [ADC_BITS-1:0] shift_word, shift_word_next;
  logic [GAIN_W-1:0]   gain_need;
  logic                take;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take       = in_valid && push_ready;

  always_comb begin
    gain_need        = (gain_pulses == '0) ? GAIN_W'(1) : gain_pulses;
    pulse_inc        = pulse_count + PCNT_W'(1);
    phase_next       = phase;
    clock_high_next  = clock_high;
    pulse_count_next = pulse_count;
    shift_word_next  = shift_word;
    push_data.sck    = 1'b0;
    push_data.sample = 1'b0;
    push_data.req    = req_type;
    push_data.word   = shift_word;
    case (phase)
      PH_IDLE: begin
        if (!dout_level) begin
          phase_next       = PH_SHIFT;
          clock_high_next  = 1'b0;
          pulse_count_next = '0;
          shift_word_next  = '0;
        end
      end
      PH_SHIFT, PH_GAIN: begin
        if (!clock_high) begin
          push_data.sck   = 1'b1;
          clock_high_next = 1'b1;
        end else begin
          clock_high_next  = 1'b0;
          pulse_count_next = pulse_inc;
          if (phase == PH_SHIFT) begin
            shift_word_next = {shift_word[ADC_BITS-2:0], dout_level};
            if (pulse_inc >= PCNT_W'(ADC_BITS)) begin
              phase_next       = PH_GAIN;
              pulse_count_next = '0;
            end
          end else if (pulse_inc >= PCNT_W'(gain_need)) begin
            push_data.sample = 1'b1;
            phase_next       = PH_IDLE;
            pulse_count_next = '0;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      clock_high  <= 1'b0;
      pulse_count <= '0;
    end else if (take) begin
      phase       <= phase_next;
      clock_high  <= clock_high_next;
      pulse_count <= pulse_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) shift_word <= shift_word_next;
  end

endmodule

/* rtl/core/lcr_back.sv */
module lcr_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  lcr_pkg::lcr_rec_t                   pop_data,
  input  logic [lcr_pkg::CAL_W-1:0]           counts_per_unit,
  input  logic [lcr_pkg::TSAMP_W-1:0]         tare_samples,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                sck_level,
  output logic                                sample_valid,
  output logic signed [lcr_pkg::RAW_W-1:0]    raw_count,
  output logic signed [lcr_pkg::WEIGHT_W-1:0] weight_q8,
  output logic                                tare_busy,
  output logic                                tare_done,
  output logic signed [lcr_pkg::RAW_W-1:0]    tare_level
);
  import lcr_pkg::*;

  bk_state_t                state, state_next;
  lcr_rec_t                 cur;
  logic signed [DIFF_W-1:0] diff;
  logic signed [RAW_W-1:0]  tare_value;
  logic signed [SUM_W-1:0]  tare_sum;
  logic [TSAMP_W-1:0]       tare_taken;
  logic                     tare_active;
  logic [WEIGHT_W-1:0]      weight_hold;
  logic                     quot_neg;

  logic                     div_start, div_done;
  logic [DIV_W-1:0]         div_dividend, div_quot;
  logic [DVSR_W-1:0]        div_divisor;

  logic                     out_free, take;
  logic                     fin, fin_sample, fin_tare, fin_req, fin_sck;
  logic                     act_mid, acc, acc_done;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         num_mag;
  logic [SUM_W-1:0]         sum_mag;
  logic [SAT_W-1:0]         qx, qx_neg;
  logic [WEIGHT_W-1:0]      weight_sat, fin_weight;
  logic signed [SUM_W-1:0]  sum_new;
  logic [TSAMP_W-1:0]       taken_new, n_eff;
  logic [DIV_W-1:0]         avg_neg;
  logic signed [RAW_W-1:0]  tare_new;

  lcr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // datapath around the divider
  always_comb begin
    out_free  = !out_valid || out_ready;
    n_eff     = (tare_samples == '0) ? TSAMP_W'(1) : tare_samples;
    num       = {diff, 8'b0};
    num_mag   = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
    sum_mag   = tare_sum[SUM_W-1] ? (~tare_sum + SUM_W'(1)) : tare_sum;
    qx        = SAT_W'(div_quot);
    qx_neg    = ~qx + SAT_W'(1);
    if (!quot_neg && (qx > SAT_W'(Q33_POS_MAG))) begin
      weight_sat = WEIGHT_MAX;
    end else if (quot_neg && (qx > SAT_W'(Q33_NEG_MAG))) begin
      weight_sat = WEIGHT_MIN;
    end else begin
      weight_sat = quot_neg ? qx_neg[WEIGHT_W-1:0] : qx[WEIGHT_W-1:0];
    end
    sum_new   = tare_sum + SUM_W'(signed'(cur.word));
    taken_new = tare_taken + TSAMP_W'(1);
    avg_neg   = ~div_quot + DIV_W'(1);
    tare_new  = quot_neg ? avg_neg[RAW_W-1:0] : div_quot[RAW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next   = state;
    pop_ready    = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(num_mag);
    div_divisor  = (counts_per_unit == '0) ? DVSR_W'(1) : DVSR_W'(counts_per_unit);
    fin          = 1'b0;
    fin_sample   = 1'b0;
    fin_tare     = 1'b0;
    fin_weight   = weight_sat;
    fin_req      = cur.req;
    fin_sck      = cur.sck;
    act_mid      = tare_active;
    acc          = 1'b0;
    acc_done     = 1'b0;
    case (state)
      BK_IDLE: begin
        pop_ready = out_free;
        fin_req   = pop_data.req;
        fin_sck   = pop_data.sck;
        if (pop_valid && out_free) begin
          if (pop_data.sample) state_next = BK_WSTART;
          else fin = 1'b1;
        end
      end
      BK_WSTART: begin
        div_start  = 1'b1;
        state_next = BK_WDIV;
      end
      BK_WDIV: begin
        if (div_done) begin
          if (tare_active && (taken_new >= n_eff)) begin
            acc_done   = 1'b1;
            state_next = BK_TSTART;
          end else begin
            acc        = tare_active;
            fin        = 1'b1;
            fin_sample = 1'b1;
            state_next = BK_IDLE;
          end
        end
      end
      BK_TSTART: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(sum_mag);
        div_divisor  = DVSR_W'(n_eff);
        state_next   = BK_TDIV;
      end
      BK_TDIV: begin
        if (div_done) begin
          fin        = 1'b1;
          fin_sample = 1'b1;
          fin_tare   = 1'b1;
          fin_weight = weight_hold;
          act_mid    = 1'b0;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign take = pop_valid && pop_ready;

  // tare state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      tare_value  <= '0;
      tare_sum    <= '0;
      tare_taken  <= '0;
      tare_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (acc) begin
        tare_sum   <= sum_new;
        tare_taken <= taken_new;
      end
      if (acc_done) tare_sum <= sum_new;
      if (fin) begin
        out_valid <= 1'b1;
        if (fin_tare) tare_value <= tare_new;
        if (fin_req && !act_mid) begin
          tare_active <= 1'b1;
          tare_sum    <= '0;
          tare_taken  <= '0;
        end else begin
          tare_active <= act_mid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur  <= pop_data;
      diff <= DIFF_W'(signed'(pop_data.word)) - DIFF_W'(tare_value);
    end
    if (state == BK_WSTART) quot_neg <= num[NUM_W-1];
    if (state == BK_TSTART) quot_neg <= tare_sum[SUM_W-1];
    if (acc_done) weight_hold <= weight_sat;
    if (fin) begin
      sck_level    <= fin_sck;
      sample_valid <= fin_sample;
      raw_count    <= fin_sample ? to_raw24(cur.word) : '0;
      weight_q8    <= fin_sample ? fin_weight : '0;
      tare_busy    <= act_mid || fin_req;
      tare_done    <= fin_tare;
      tare_level   <= fin_tare ? tare_new : tare_value;
    end
  end

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == BK_WDIV || state == BK_TDIV))
    else $error("divider finished outside a divide state");

  a_out_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight_q8) && $stable(tare_level))
    else $error("pending result changed before it was taken");

  a_tare_with_reading: assert property (@(posedge clk) disable iff (rst)
    out_valid && tare_done |-> sample_valid)
    else $error("tare stored without a completed reading");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lcr_pkg::*;

  // reading extremes at the converter width
  localparam logic [ADC_BITS-1:0] READ_MAX = {1'b0, {(ADC_BITS-1){1'b1}}};
  localparam logic [ADC_BITS-1:0] READ_MIN = {1'b1, {(ADC_BITS-1){1'b0}}};

  // 33-bit signed weight range
  localparam longint WEIGHT_HI = 64'sd4294967295;
  localparam longint WEIGHT_LO = -64'sd4294967296;

  // index with no register behind it, writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // ticks worth of dout high that always brings the converter back to idle
  localparam int FLUSH_TICKS = 56;

  // rough number of tick items for the whole run
  localparam int unsigned TICK_TARGET = 500;

  // where a tare request rides inside a reading
  typedef enum {
    REQ_NONE,
    REQ_ON_START,
    REQ_ON_END
  } req_at_t;

  // one tick item as offered to the block
  typedef struct packed {
    logic req;
    logic dout;
  } tick_t;

  // one result item as the block should return it
  typedef struct packed {
    logic                       sck;
    logic                       valid;
    logic signed [RAW_W-1:0]    raw;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       busy;
    logic                       done;
    logic signed [RAW_W-1:0]    tare;
  } readout_t;

  // clock, reset and block ports
  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       req_type = 1'b0;
  logic                       dout_level = 1'b1;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       sck_level;
  logic                       sample_valid;
  logic signed [RAW_W-1:0]    raw_count;
  logic signed [WEIGHT_W-1:0] weight_q8;
  logic                       tare_busy;
  logic                       tare_done;
  logic signed [RAW_W-1:0]    tare_level;

  // stimulus and expectations
  tick_t    tick_queue[$];
  readout_t readouts_due[$];
  readout_t want;
  tick_t    next_tick;

  // predictor copy of the registers
  logic [CAL_W-1:0]   cal_div = CAL_RESET;
  logic [TSAMP_W-1:0] tare_count_cfg = TSAMP_RESET;
  logic [GAIN_W-1:0]  gain_cfg = GAIN_RESET;

  // predictor copy of the converter and tare state
  phase_t              conv_phase = PH_IDLE;
  bit                  sck_high = 1'b0;
  int unsigned         pulses = 0;
  logic [ADC_BITS-1:0] shift_reg = '0;
  longint              tare_now = 0;
  longint              tare_acc = 0;
  int unsigned         tare_cnt = 0;
  bit                  tare_on = 1'b0;

  // generator knobs
  int unsigned cur_extra = 1;
  int unsigned stray_req_pct = 0;

  // handshake pacing
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b1;
  logic        rx_hold = 1'b0;

  // bookkeeping
  int unsigned err_count = 0;
  int unsigned ticks_queued = 0;
  int unsigned ticks_taken = 0;
  int unsigned results_checked = 0;
  int unsigned readings_seen = 0;
  int unsigned tares_seen = 0;
  int unsigned settings_done = 0;

  load_cell_adc_reader_with_tare dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // safety net against a hung handshake
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor: one tick in, one readout out
  // ---------------------------------------------------------------------------
  function automatic readout_t convert_tick(input logic req, input logic dout);
    readout_t    r;
    longint      raw;
    longint      wt;
    longint      divisor;
    longint      n;
    longint      q;
    int unsigned need;
    r = '0;
    if (conv_phase == PH_IDLE) begin
      // dout low means a conversion is ready to be clocked out
      if (!dout) begin
        conv_phase = PH_SHIFT;
        sck_high = 1'b0;
        pulses = 0;
        shift_reg = '0;
      end
    end else if (!sck_high) begin
      r.sck = 1'b1;
      sck_high = 1'b1;
    end else begin
      // low half of a pulse: data bits get sampled here
      sck_high = 1'b0;
      if (conv_phase == PH_SHIFT) begin
        shift_reg = {shift_reg[ADC_BITS-2:0], dout};
        pulses++;
        if (pulses >= ADC_BITS) begin
          conv_phase = PH_GAIN;
          pulses = 0;
        end
      end else begin
        need = (gain_cfg == 0) ? 1 : gain_cfg;
        pulses++;
        if (pulses >= need) begin
          raw = $signed(shift_reg);
          divisor = (cal_div == 0) ? 1 : longint'(cal_div);
          // signed divide truncates toward zero
          wt = ((raw - tare_now) * 256) / divisor;
          if (wt > WEIGHT_HI) wt = WEIGHT_HI;
          if (wt < WEIGHT_LO) wt = WEIGHT_LO;
          r.valid = 1'b1;
          r.raw = raw[RAW_W-1:0];
          r.weight = wt[WEIGHT_W-1:0];
          conv_phase = PH_IDLE;
          pulses = 0;
          readings_seen++;
          // the weight above still used the old tare
          if (tare_on) begin
            n = (tare_count_cfg == 0) ? 1 : longint'(tare_count_cfg);
            tare_acc += raw;
            tare_cnt++;
            if (tare_cnt >= n) begin
              q = tare_acc / n;
              tare_now = $signed(q[RAW_W-1:0]);
              tare_on = 1'b0;
              r.done = 1'b1;
              tares_seen++;
            end
          end
        end
      end
    end
    // request lands after this tick's reading, ignored while averaging
    if (req && !tare_on) begin
      tare_on = 1'b1;
      tare_acc = 0;
      tare_cnt = 0;
    end
    r.busy = tare_on;
    r.tare = tare_now[RAW_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building blocks
  // ---------------------------------------------------------------------------
  function automatic void push_tick(input logic req, input logic dout);
    tick_queue.push_back('{req: req, dout: dout});
    ticks_queued++;
  endfunction

  function automatic logic stray_req();
    return $urandom_range(0, 99) < stray_req_pct;
  endfunction

  // full well-formed frame: idle wait, start, data pulses, gain pulses
  function automatic void push_reading(input logic [ADC_BITS-1:0] value,
                                       input int unsigned lead, input req_at_t req_at);
    repeat (lead) push_tick(stray_req(), 1'b1);
    push_tick((req_at == REQ_ON_START) || stray_req(), 1'b0);
    for (int i = ADC_BITS - 1; i >= 0; i--) begin
      // dout is don't-care on the high half
      push_tick(stray_req(), 1'($urandom_range(0, 1)));
      push_tick(stray_req(), value[i]);
    end
    for (int k = 0; k < 2 * cur_extra; k++) begin
      push_tick(((k == 2 * cur_extra - 1) && (req_at == REQ_ON_END)) || stray_req(),
                1'($urandom_range(0, 1)));
    end
  endfunction

  // broken frame: random levels, then dout high long enough to end any frame
  function automatic void push_noise();
    repeat ($urandom_range(1, 30)) push_tick(stray_req(), 1'($urandom_range(0, 1)));
    repeat (FLUSH_TICKS) push_tick(stray_req(), 1'b1);
  endfunction

  function automatic logic [ADC_BITS-1:0] pick_reading();
    case ($urandom_range(0, 7))
      0: return READ_MAX;
      1: return READ_MIN;
      2: return '0;
      3: return '1;
      4: return ADC_BITS'($urandom_range(0, 15));
      5: return -ADC_BITS'($urandom_range(1, 16));
      default: return ADC_BITS'($urandom());
    endcase
  endfunction

  // mostly short gaps, now and then a long one, none in calm stretches
  function automatic int unsigned draw_gap(input bit calm);
    int unsigned pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic flag_mismatch(input string what, input logic signed [63:0] got,
                               input logic signed [63:0] exp_val);
    $display("[%0t] mismatch on %s at result %0d: got %0d, wanted %0d",
             $realtime, what, results_checked, got, exp_val);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // register writes, only issued while nothing is in flight
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CAL_FACTOR:   cal_div = val[CAL_W-1:0];
      CFG_TARE_SAMPLES: tare_count_cfg = val[TSAMP_W-1:0];
      CFG_GAIN_PULSES:  gain_cfg = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CAL_W-1:0] cal, input logic [TSAMP_W-1:0] ts,
                               input logic [GAIN_W-1:0] gn);
    logic [CFG_DATA_W-1:0] word;
    write_reg(CFG_CAL_FACTOR, cal);
    // junk in the unused upper bits, the register keeps only its own width
    word = CFG_DATA_W'($urandom());
    word[TSAMP_W-1:0] = ts;
    write_reg(CFG_TARE_SAMPLES, word);
    word = CFG_DATA_W'($urandom());
    word[GAIN_W-1:0] = gn;
    write_reg(CFG_GAIN_PULSES, word);
    cur_extra = (gn == 0) ? 1 : gn;
    settings_done++;
  endtask

  // sender pause: hold off until every result already owed has arrived
  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid || readouts_due.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: feeds tick items from the queue with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      req_type <= 1'b0;
      dout_level <= 1'b1;
      tx_gap = 0;
    end else begin
      if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
      // slot is free when nothing is offered or the offer is taken now
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          next_tick = tick_queue.pop_front();
          in_valid <= 1'b1;
          req_type <= next_tick.req;
          dout_level <= next_tick.dout;
          tx_gap = draw_gap(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on accepted ticks, then checks accepted results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      // predict first so a same-edge result still finds its expectation
      if (in_valid && in_ready) begin
        readouts_due.push_back(convert_tick(req_type, dout_level));
        ticks_taken++;
      end
      if (out_valid && out_ready) begin
        if (readouts_due.size() == 0) begin
          flag_mismatch("result with nothing pending", 0, 0);
        end else begin
          want = readouts_due.pop_front();
          if (sck_level !== want.sck) flag_mismatch("sck_level", sck_level, want.sck);
          if (sample_valid !== want.valid)
            flag_mismatch("sample_valid", sample_valid, want.valid);
          if (raw_count !== want.raw) flag_mismatch("raw_count", raw_count, want.raw);
          if (weight_q8 !== want.weight) flag_mismatch("weight_q8", weight_q8, want.weight);
          if (tare_busy !== want.busy) flag_mismatch("tare_busy", tare_busy, want.busy);
          if (tare_done !== want.done) flag_mismatch("tare_done", tare_done, want.done);
          if (tare_level !== want.tare) flag_mismatch("tare_level", tare_level, want.tare);
        end
        results_checked++;
      end
      // receiver pacing, with a forced hold from the pressure process
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (rx_gap != 0) rx_gap--;
      else if (out_valid && out_ready) rx_gap = draw_gap(rx_calm);
      out_ready <= (rx_gap == 0) && !rx_hold;
    end
  end

  // long receiver stalls while ticks keep coming, so the block backs up
  initial begin
    while (ticks_taken < 40) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
    while (ticks_taken < 150) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (250) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sequence: directed frames, then random settings with random frames
  // ---------------------------------------------------------------------------
  initial begin
    logic [CAL_W-1:0]   cal;
    logic [TSAMP_W-1:0] ts;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: divide by 1, ten-sample tare, one gain pulse
    push_reading(READ_MAX, 0, REQ_NONE);
    // request on the completing tick: that reading is not averaged
    push_reading(READ_MIN, 3, REQ_ON_END);
    wait_drained();

    // zero divisor, single-sample tare, widest gain select
    apply_setting('0, 8'd1, 2'd3);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    // request while averaging is ignored, and this reading closes the tare
    // with its weight still on the old tare
    push_reading(READ_MAX, 0, REQ_ON_START);
    // opposite tare gives the largest weights of either sign
    push_reading(READ_MIN, 0, REQ_ON_START);
    push_reading(READ_MAX, 2, REQ_NONE);
    wait_drained();

    // largest divisor, zero tare count and zero gain pulses
    apply_setting('1, 8'd0, 2'd0);
    push_reading(pick_reading(), 0, REQ_ON_START);
    push_noise();
    push_reading(READ_MIN, 1, REQ_NONE);
    wait_drained();

    // random part: a new setting per frame until the tick budget is used
    stray_req_pct = 3;
    while (ticks_queued < TICK_TARGET) begin
      case ($urandom_range(0, 5))
        0: cal = CAL_W'(1);
        1: cal = '1;
        2: cal = '0;
        3, 4: cal = CAL_W'($urandom_range(1, 255));
        default: cal = CAL_W'($urandom());
      endcase
      case ($urandom_range(0, 9))
        0: ts = '1;
        1: ts = '0;
        default: ts = TSAMP_W'($urandom_range(1, 4));
      endcase
      apply_setting(cal, ts, GAIN_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 7) == 0) push_noise();
      push_reading(pick_reading(),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2),
                   ($urandom_range(0, 3) == 0) ? REQ_ON_START :
                   ($urandom_range(0, 9) == 0) ? REQ_ON_END : REQ_NONE);
      wait_drained();
    end

    // make sure every owed result has arrived, then give the block time to settle
    wait_drained();
    repeat (100) @(posedge clk);

    $display("covered %0d ticks, %0d readings and %0d completed tares",
             ticks_taken, readings_seen, tares_seen);
    $display("across %0d register settings, %0d results checked, %0d mismatches",
             settings_done + 1, results_checked, err_count);
    if (err_count == 0 && readouts_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lcr_pkg.sv
rtl/core/lcr_div.sv
rtl/core/lcr_fifo.sv
rtl/core/lcr_front.sv
rtl/core/lcr_back.sv
rtl/core/load_cell_adc_reader_with_tare.sv
tb/testbench.sv
